// File: sv/ordered_list_buffer_dump_core_defines.svh
// Assertion macros shared by the list buffer RTL.
`ifndef ORDERED_LIST_BUFFER_DUMP_CORE_DEFINES_SVH
`define ORDERED_LIST_BUFFER_DUMP_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OLBD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("olbd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define OLBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("olbd assertion failed");

`endif

// File: sv/olbd_pkg.sv
package olbd_pkg;

	// list geometry
	localparam int CAPACITY = 32;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// field widths
	localparam int OPCODE_W  = 2;
	localparam int VALUE_W   = 32;
	localparam int IN_DATA_W = ((OPCODE_W + VALUE_W + 7) / 8) * 8;
	localparam int OUT_USER_W = 4;

	// input opcodes
	typedef enum logic [OPCODE_W-1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_PUSH_BACK  = 2'd1,
		OP_DELETE     = 2'd2,
		OP_DUMP       = 2'd3
	} op_t;

	// per-cell next-value source
	typedef enum logic [1:0] {
		SEL_HOLD  = 2'd0,
		SEL_LEFT  = 2'd1,
		SEL_RIGHT = 2'd2,
		SEL_BCAST = 2'd3
	} cell_sel_t;

	typedef logic signed [VALUE_W-1:0] value_t;

endpackage

// File: sv/olbd_cell.sv
// One list slot: loads from a neighbor or the broadcast bus, drives the tail bus.
module olbd_cell (
	input  logic                clk,
	input  olbd_pkg::cell_sel_t sel,
	input  olbd_pkg::value_t    left_d,
	input  olbd_pkg::value_t    right_d,
	input  olbd_pkg::value_t    bcast_d,
	input  logic                is_tail,
	output olbd_pkg::value_t    data,
	output olbd_pkg::value_t    tail_d
);

	olbd_pkg::value_t data_q;

	// slot register
	always_ff @(posedge clk) begin
		case (sel)
			olbd_pkg::SEL_LEFT:  data_q <= left_d;
			olbd_pkg::SEL_RIGHT: data_q <= right_d;
			olbd_pkg::SEL_BCAST: data_q <= bcast_d;
			default:             data_q <= data_q;
		endcase
	end

	assign data   = data_q;
	// gated onto the OR bus only by the current tail slot
	assign tail_d = is_tail ? data_q : '0;

endmodule

// File: sv/ordered_list_buffer_dump_core.sv
// Order: an accepted input word moves the control state to the forward pass, and the first
//   result word is then loaded into the output word register.
// Throughput: one result word per cycle while m_tready does not stall it, set by the single
//   rotation step of the cell chain; a new input word is taken only after both passes end.
// Reset: arst_n clears the entry count, control state and output valid; slot contents
//   stay undefined and are never shown before being written.
module ordered_list_buffer_dump_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// [1:0] opcode, [33:2] operand, rest zero
	input  logic [olbd_pkg::IN_DATA_W-1:0]        s_tdata,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// [31:0] element
	output logic [olbd_pkg::VALUE_W-1:0]          m_tdata,
	// [0] reverse_pass, [1] has_value, [2] pass_end, [3] dropped
	output logic [olbd_pkg::OUT_USER_W-1:0]       m_tuser,
	output logic                                  m_tlast
);

	localparam int CAP   = olbd_pkg::CAPACITY;
	localparam int CNT_W = olbd_pkg::CNT_W;
	localparam int IDX_W = olbd_pkg::IDX_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FWD,
		ST_REV
	} state_t;

	state_t                  state_q;
	logic [CNT_W-1:0]        n_q;
	logic [IDX_W-1:0]        k_q;
	logic                    drop_q;
	logic                    m_tvalid_q;
	olbd_pkg::value_t        m_elem_q;
	logic                    m_rev_q;
	logic                    m_hasv_q;
	logic                    m_pend_q;
	logic                    m_drop_q;
	logic                    m_last_q;

	olbd_pkg::op_t           op;
	olbd_pkg::value_t        operand;
	logic                    accept;
	logic                    full;
	logic                    del_ok;
	logic [CNT_W-1:0]        pos;
	logic [CNT_W-1:0]        n_next;
	logic                    step;
	logic                    is_empty;
	logic                    at_end;
	olbd_pkg::value_t        bcast;
	olbd_pkg::value_t        tail;

	olbd_pkg::value_t        cell_data [CAP];
	olbd_pkg::value_t        cell_tail [CAP];
	olbd_pkg::cell_sel_t     cell_sel  [CAP];

	// input decode
	assign op       = olbd_pkg::op_t'(s_tdata[olbd_pkg::OPCODE_W-1:0]);
	assign operand  = s_tdata[olbd_pkg::OPCODE_W +: olbd_pkg::VALUE_W];
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign full     = (n_q == CNT_W'(CAP));
	assign del_ok   = !operand[olbd_pkg::VALUE_W-1] &&
		(operand < olbd_pkg::value_t'({{(olbd_pkg::VALUE_W-CNT_W){1'b0}}, n_q}));
	assign pos      = CNT_W'(operand[IDX_W-1:0]);

	// count after the operation
	always_comb begin
		n_next = n_q;
		case (op)
			olbd_pkg::OP_PUSH_FRONT,
			olbd_pkg::OP_PUSH_BACK: if (!full) n_next = n_q + CNT_W'(1);
			olbd_pkg::OP_DELETE:    if (del_ok) n_next = n_q - CNT_W'(1);
			default:                n_next = n_q;
		endcase
	end

	// listing progress
	assign step     = (!m_tvalid_q || m_tready);
	assign is_empty = (n_q == '0);
	assign at_end   = is_empty || ((CNT_W'(k_q) + CNT_W'(1)) == n_q);

	// tail OR bus
	always_comb begin
		tail = '0;
		for (int j = 0; j < CAP; j++) begin
			tail = tail | cell_tail[j];
		end
	end

	// broadcast source
	always_comb begin
		case (state_q)
			ST_FWD:  bcast = cell_data[0];
			ST_REV:  bcast = tail;
			default: bcast = operand;
		endcase
	end

	// cell chain
	for (genvar i = 0; i < CAP; i++) begin : g_cell
		localparam logic [CNT_W-1:0] I_C = CNT_W'(i);
		olbd_pkg::value_t left_d;
		olbd_pkg::value_t right_d;

		if (i == 0) begin : g_first
			assign left_d = '0;
		end else begin : g_mid_l
			assign left_d = cell_data[i-1];
		end
		if (i == CAP - 1) begin : g_lastc
			assign right_d = '0;
		end else begin : g_mid_r
			assign right_d = cell_data[i+1];
		end

		// slot source select
		always_comb begin
			cell_sel[i] = olbd_pkg::SEL_HOLD;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (op)
							olbd_pkg::OP_PUSH_FRONT: begin
								if (!full) cell_sel[i] = (i == 0) ?
									olbd_pkg::SEL_BCAST : olbd_pkg::SEL_LEFT;
							end
							olbd_pkg::OP_PUSH_BACK: begin
								if (!full && I_C == n_q) cell_sel[i] = olbd_pkg::SEL_BCAST;
							end
							olbd_pkg::OP_DELETE: begin
								if (del_ok && I_C >= pos && (I_C + CNT_W'(1)) < n_q)
									cell_sel[i] = olbd_pkg::SEL_RIGHT;
							end
							default: cell_sel[i] = olbd_pkg::SEL_HOLD;
						endcase
					end
				end
				ST_FWD: begin
					// rotate left, head wraps to the tail slot
					if (step && !is_empty) begin
						if ((I_C + CNT_W'(1)) < n_q) cell_sel[i] = olbd_pkg::SEL_RIGHT;
						else if ((I_C + CNT_W'(1)) == n_q) cell_sel[i] = olbd_pkg::SEL_BCAST;
					end
				end
				ST_REV: begin
					// rotate right, tail wraps to the head slot
					if (step && !is_empty) begin
						if (i == 0) cell_sel[i] = olbd_pkg::SEL_BCAST;
						else if (I_C < n_q) cell_sel[i] = olbd_pkg::SEL_LEFT;
					end
				end
				default: cell_sel[i] = olbd_pkg::SEL_HOLD;
			endcase
		end

		olbd_cell u_cell (
			.clk     (clk),
			.sel     (cell_sel[i]),
			.left_d  (left_d),
			.right_d (right_d),
			.bcast_d (bcast),
			.is_tail ((I_C + CNT_W'(1)) == n_q),
			.data    (cell_data[i]),
			.tail_d  (cell_tail[i])
		);
	end

	// control and output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			n_q        <= '0;
			k_q        <= '0;
			drop_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_elem_q   <= '0;
			m_rev_q    <= 1'b0;
			m_hasv_q   <= 1'b0;
			m_pend_q   <= 1'b0;
			m_drop_q   <= 1'b0;
			m_last_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					// final word of the previous item may still be waiting
					if (m_tvalid_q && m_tready) m_tvalid_q <= 1'b0;
					if (accept) begin
						n_q     <= n_next;
						k_q     <= '0;
						drop_q  <= full && (op == olbd_pkg::OP_PUSH_FRONT ||
							op == olbd_pkg::OP_PUSH_BACK);
						state_q <= ST_FWD;
					end
				end
				ST_FWD, ST_REV: begin
					if (step) begin
						m_tvalid_q <= 1'b1;
						m_elem_q   <= is_empty ? '0 :
							((state_q == ST_FWD) ? cell_data[0] : tail);
						m_rev_q    <= (state_q == ST_REV);
						m_hasv_q   <= !is_empty;
						m_pend_q   <= at_end;
						m_drop_q   <= drop_q;
						m_last_q   <= at_end && (state_q == ST_REV);
						if (at_end) begin
							k_q     <= '0;
							state_q <= (state_q == ST_FWD) ? ST_REV : ST_IDLE;
						end else begin
							k_q <= k_q + IDX_W'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_elem_q;
	assign m_tuser  = {m_drop_q, m_pend_q, m_hasv_q, m_rev_q};
	assign m_tlast  = m_last_q;

`include "ordered_list_buffer_dump_core_defines.svh"

	`OLBD_ASSERT_NEXT(a_accept_busy, clk, arst_n, accept, state_q != ST_IDLE)
	`OLBD_ASSERT_IMPL(a_count_cap, clk, arst_n, 1'b1, n_q <= CNT_W'(CAP))
	`OLBD_ASSERT_IMPL(a_last_rev_end, clk, arst_n, m_tvalid && m_tlast, m_tuser[2] && m_tuser[0])

endmodule
